### hdl/bncm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bncm_pkg
// Shared widths, register indexes, reset values and pipeline control types
// for the bitcrusher with dry/wet mix.
// ----------------------------------------------------------------------------
package bncm_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DRAW_W     = 7;
	localparam int PCT_W      = 7;
	localparam int MIXREG_W   = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int IN_TDATA_W = 56;
	localparam int OUT_TDATA_W = 16;

	localparam int MIX_FRAC_BITS_DEF = 8;

	localparam logic [PCT_W-1:0]    GLITCH_DENSITY_RST = 7'd0;
	localparam logic [PCT_W-1:0]    NOISE_AMOUNT_RST   = 7'd0;
	localparam logic [MIXREG_W-1:0] MIX_AMOUNT_RST     = 9'd128;

	// floor(a / 100) == (a * DIV100_MUL) >> DIV100_SHIFT for every a below 2^22
	localparam logic [22:0] DIV100_MUL   = 23'd5368710;
	localparam int          DIV100_SHIFT = 29;

	// floor(n / 10) == (n * DIV10_MUL) >> DIV10_SHIFT for every 7-bit n
	localparam logic [7:0] DIV10_MUL   = 8'd205;
	localparam int         DIV10_SHIFT = 11;

	localparam int NUM_STAGES = 6;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GLITCH_DENSITY = 2'd0,
		REG_NOISE_AMOUNT   = 2'd1,
		REG_MIX_AMOUNT     = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} pipe_ctl_t;

endpackage : bncm_pkg
`default_nettype wire

### hdl/bncm_pipe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bncm_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty
// or its content moves on, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
module bncm_pipe_ctrl
	import bncm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      out_ready,
	output pipe_ctl_t      ctl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule : bncm_pipe_ctrl
`default_nettype wire

### hdl/bncm_crush.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bncm_crush
// Stages 1 to 3: bit-depth reduction toward zero, scaled noise with an
// exact divide by 100, clamp, and selection of the wet sample.
// ----------------------------------------------------------------------------
module bncm_crush
	import bncm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic [2:0]                 en,
	input  wire logic [PCT_W-1:0]           glitch_density,
	input  wire logic [PCT_W-1:0]           noise_amount,
	input  wire logic signed [SAMPLE_W-1:0] clean_sample,
	input  wire logic signed [SAMPLE_W-1:0] dirty_sample,
	input  wire logic [DRAW_W-1:0]          glitch_draw,
	input  wire logic signed [SAMPLE_W-1:0] noise_draw,
	output logic signed [SAMPLE_W-1:0]      clean_s3,
	output logic signed [SAMPLE_W:0]        dirty_s3
);

	// stage 1
	logic [14:0]             na_x205;
	logic [3:0]              na_div10;
	logic [3:0]              shamt;
	logic [SAMPLE_W:0]       lsb_mask;
	logic signed [SAMPLE_W:0] dirty_x;
	logic signed [SAMPLE_W:0] biased;
	logic signed [23:0]      prod;

	logic signed [SAMPLE_W-1:0] clean_s1;
	logic signed [SAMPLE_W-1:0] dirty_s1;
	logic signed [SAMPLE_W:0]   crushed_s1;
	logic signed [23:0]         prod_s1;
	logic                       crush_s1;

	always_comb begin
		na_x205  = 15'(noise_amount) * 15'(DIV10_MUL);
		na_div10 = 4'(na_x205 >> DIV10_SHIFT);
		// depth floors at 3 bits, which is a 13-bit step
		shamt    = (na_div10 >= 4'd6) ? 4'd13 : 4'd7 + na_div10;
		lsb_mask = (17'd1 << shamt) - 17'd1;
		dirty_x  = 17'(dirty_sample);
		biased   = dirty_x + (dirty_x < 0 ? $signed(lsb_mask) : 17'sd0);
		prod     = 24'(noise_draw) * 24'($signed({1'b0, noise_amount}));
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			clean_s1   <= clean_sample;
			dirty_s1   <= dirty_sample;
			crushed_s1 <= $signed(biased & ~lsb_mask);
			prod_s1    <= prod;
			crush_s1   <= glitch_draw < glitch_density;
		end
	end

	// stage 2: magnitude times reciprocal of 100
	logic [21:0] mag;
	logic [44:0] rprod;

	logic signed [SAMPLE_W-1:0] clean_s2;
	logic signed [SAMPLE_W-1:0] dirty_s2;
	logic signed [SAMPLE_W:0]   crushed_s2;
	logic [15:0]                quot_s2;
	logic                       neg_s2;
	logic                       crush_s2;

	always_comb begin
		mag   = prod_s1[23] ? 22'(-prod_s1) : 22'(prod_s1);
		rprod = 45'(mag) * 45'(DIV100_MUL);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			clean_s2   <= clean_s1;
			dirty_s2   <= dirty_s1;
			crushed_s2 <= crushed_s1;
			quot_s2    <= rprod[DIV100_SHIFT +: 16];
			neg_s2     <= prod_s1[23];
			crush_s2   <= crush_s1;
		end
	end

	// stage 3: restore sign, add, clamp to full scale, select
	logic signed [SAMPLE_W:0]   qx;
	logic signed [SAMPLE_W:0]   noise;
	logic signed [SAMPLE_W+1:0] sum;
	logic signed [SAMPLE_W:0]   clamped;

	always_comb begin
		qx    = $signed({1'b0, quot_s2});
		noise = neg_s2 ? -qx : qx;
		sum   = 18'(crushed_s2) + 18'(noise);
		if (sum > 18'sd32768) begin
			clamped = 17'sd32768;
		end else if (sum < -18'sd32768) begin
			clamped = -17'sd32768;
		end else begin
			clamped = 17'(sum);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			clean_s3 <= clean_s2;
			dirty_s3 <= crush_s2 ? clamped : 17'(dirty_s2);
		end
	end

endmodule : bncm_crush
`default_nettype wire

### hdl/bncm_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bncm_mix
// Stages 4 to 6: weighted dry/wet products, divide by the mix scale toward
// zero with clamp, then output scaling by 32767/32768.
// ----------------------------------------------------------------------------
module bncm_mix
	import bncm_pkg::*;
#(
	parameter int MIX_FRACTION_BITS = MIX_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic [2:0]                 en,
	input  wire logic [MIXREG_W-1:0]        mix_amount,
	input  wire logic signed [SAMPLE_W-1:0] clean_s3,
	input  wire logic signed [SAMPLE_W:0]   dirty_s3,
	output logic signed [SAMPLE_W-1:0]      mixed_s6
);

	localparam int MW = (MIX_FRACTION_BITS + 1 > MIXREG_W) ? MIX_FRACTION_BITS + 1 : MIXREG_W;
	localparam int PW = MW + 18;
	localparam int SW = PW + 1;
	localparam logic [MW-1:0]        SCALE  = MW'(1 << MIX_FRACTION_BITS);
	localparam logic signed [SW-1:0] BIAS   = SW'((1 << MIX_FRACTION_BITS) - 1);
	localparam logic signed [SW-1:0] POS_FS = SW'(32768);
	localparam logic signed [SW-1:0] NEG_FS = -SW'(32768);

	// stage 4: saturate weight, form both products
	logic [MW-1:0] m_sat;
	logic [MW-1:0] w_clean;

	logic signed [PW-1:0] pc_s4;
	logic signed [PW-1:0] pd_s4;

	always_comb begin
		m_sat   = (MW'(mix_amount) > SCALE) ? SCALE : MW'(mix_amount);
		w_clean = SCALE - m_sat;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pc_s4 <= PW'(clean_s3) * PW'($signed({1'b0, w_clean}));
			pd_s4 <= PW'(dirty_s3) * PW'($signed({1'b0, m_sat}));
		end
	end

	// stage 5: sum, truncate toward zero, clamp
	logic signed [SW-1:0]     sum;
	logic signed [SW-1:0]     quot;
	logic signed [SAMPLE_W:0] mix_c;

	logic signed [SAMPLE_W:0] mix_s5;

	always_comb begin
		sum  = SW'(pc_s4) + SW'(pd_s4);
		quot = (sum + (sum < 0 ? BIAS : SW'(0))) >>> MIX_FRACTION_BITS;
		if (quot > POS_FS) begin
			mix_c = 17'sd32768;
		end else if (quot < NEG_FS) begin
			mix_c = -17'sd32768;
		end else begin
			mix_c = 17'(quot);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			mix_s5 <= mix_c;
		end
	end

	// stage 6: times 32767 as shift and subtract, truncate toward zero
	logic signed [32:0] scaled;
	logic signed [32:0] scaled_b;

	always_comb begin
		scaled   = (33'(mix_s5) <<< 15) - 33'(mix_s5);
		scaled_b = scaled + (scaled < 0 ? 33'sd32767 : 33'sd0);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			mixed_s6 <= 16'(scaled_b >>> 15);
		end
	end

endmodule : bncm_mix
`default_nettype wire

### hdl/bitcrush_noise_dry_wet_mixer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitcrush_noise_dry_wet_mixer_top
// Per-sample bitcrusher with scaled noise and dry/wet blend.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transfer carries a clean and a dirty sample plus
//   a glitch draw and a noise draw. Output stream (m_*): one transfer per
//   input carries the blended sample, in input order.
//   Configuration (cfg_*): write glitch density, noise amount and mix amount
//   by index while the stream is idle; writes take effect on the next edge.
//   Pipeline: six register stages (crush/product, reciprocal divide by 100,
//   noise clamp and select, mix products, mix divide and clamp, output
//   scaling). The first stage loads on the input transfer edge, and m_tvalid
//   rises once that sample reaches the last stage.
//   Throughput: one sample per cycle while m_tready is high; the six-stage
//   pipeline with a load enable per stage sets that figure.
//   Reset: clears all valid bits and loads the register reset values
//   (density 0, noise 0, mix 128).
//   Stall: when m_tready is low the last stage holds its result; earlier
//   stages keep advancing into empty slots and s_tready drops only once
//   every stage holds a sample.
// ----------------------------------------------------------------------------
module bitcrush_noise_dry_wet_mixer_top
	import bncm_pkg::*;
#(
	parameter int MIX_FRACTION_BITS = MIX_FRAC_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [15:0] clean_sample, [31:16] dirty_sample, [38:32] glitch_draw,
	// [54:39] noise_draw, [55] zero fill
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// output stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [15:0] mixed_sample
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_addr,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	// configuration registers
	logic [PCT_W-1:0]    glitch_density_q;
	logic [PCT_W-1:0]    noise_amount_q;
	logic [MIXREG_W-1:0] mix_amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glitch_density_q <= GLITCH_DENSITY_RST;
			noise_amount_q   <= NOISE_AMOUNT_RST;
			mix_amount_q     <= MIX_AMOUNT_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GLITCH_DENSITY: glitch_density_q <= cfg_wdata[PCT_W-1:0];
				REG_NOISE_AMOUNT:   noise_amount_q   <= cfg_wdata[PCT_W-1:0];
				REG_MIX_AMOUNT:     mix_amount_q     <= cfg_wdata[MIXREG_W-1:0];
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	// pipeline control: valid bits and stage load enables
	pipe_ctl_t ctl;

	bncm_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.out_ready (m_tready),
		.ctl       (ctl)
	);

	assign s_tready = ctl.en[0];
	assign m_tvalid = ctl.vld[NUM_STAGES-1];

	// unpack the input transfer
	logic signed [SAMPLE_W-1:0] clean_in;
	logic signed [SAMPLE_W-1:0] dirty_in;
	logic [DRAW_W-1:0]          gdraw_in;
	logic signed [SAMPLE_W-1:0] ndraw_in;

	assign clean_in = $signed(s_tdata[15:0]);
	assign dirty_in = $signed(s_tdata[31:16]);
	assign gdraw_in = s_tdata[38:32];
	assign ndraw_in = $signed(s_tdata[54:39]);

	// stages 1-3: crush, noise, select wet sample
	logic signed [SAMPLE_W-1:0] clean_s3;
	logic signed [SAMPLE_W:0]   dirty_s3;

	bncm_crush u_crush (
		.clk            (clk),
		.en             (ctl.en[2:0]),
		.glitch_density (glitch_density_q),
		.noise_amount   (noise_amount_q),
		.clean_sample   (clean_in),
		.dirty_sample   (dirty_in),
		.glitch_draw    (gdraw_in),
		.noise_draw     (ndraw_in),
		.clean_s3       (clean_s3),
		.dirty_s3       (dirty_s3)
	);

	// stages 4-6: blend and output scaling
	logic signed [SAMPLE_W-1:0] mixed_s6;

	bncm_mix #(
		.MIX_FRACTION_BITS (MIX_FRACTION_BITS)
	) u_mix (
		.clk        (clk),
		.en         (ctl.en[5:3]),
		.mix_amount (mix_amount_q),
		.clean_s3   (clean_s3),
		.dirty_s3   (dirty_s3),
		.mixed_s6   (mixed_s6)
	);

	assign m_tdata = mixed_s6;

`ifndef ASSERT_OFF
	// output scaling can never reach negative full scale
	a_no_neg_fs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("mixed sample reached -32768");

	// an empty output slot lets the whole chain accept
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output stage");

	// a full pipeline behind a stalled output must block the input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&ctl.vld && !m_tready) |-> !s_tready)
		else $error("input accepted into a full, stalled pipeline");

	// a stalled result stays put for the next cycle
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(mixed_s6)))
		else $error("stalled result changed");
`endif

endmodule : bitcrush_noise_dry_wet_mixer_top
`default_nettype wire
